>>> rtl/core/rpit_pkg.sv
// Package for the relay pulse interlock timer.
// Word layouts, command codes and field widths; no dependencies.
package rpit_pkg;

  localparam int IDX_W = 3;
  localparam int DUR_W = 24;
  localparam int IMG_W = 8;

  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_TRIGGER = 1'b1;

  typedef struct packed {
    logic             cmd;
    logic [IDX_W-1:0] relay_index;
    logic [DUR_W-1:0] pulse_ms;
  } item_t;

  typedef struct packed {
    logic [IMG_W-1:0] relay_bits;
    logic             accepted;
    logic             send_update;
  } result_t;

endpackage

>>> rtl/core/rpit_core.sv
// Relay image, per-relay pulse countdowns and the trigger interlock.
// Uses rpit_pkg; one word is processed per cycle when go is high.
module rpit_core #(
  parameter int RELAY_COUNT   = 8,
  parameter int DURATION_BITS = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  rpit_pkg::item_t  item,
  output rpit_pkg::result_t res
);

  localparam int SLOTS = (RELAY_COUNT < rpit_pkg::IMG_W) ? RELAY_COUNT : rpit_pkg::IMG_W;
  localparam logic [32:0] DUR_MAX = (33'd1 << DURATION_BITS) - 33'd1;

  logic [rpit_pkg::IMG_W-1:0] img;
  logic [rpit_pkg::IMG_W-1:0] img_next;
  logic [rpit_pkg::IMG_W-1:0] last_sent;
  logic [rpit_pkg::IMG_W-1:0] busy;
  logic [rpit_pkg::IMG_W-1:0] ends;
  logic [rpit_pkg::IMG_W-1:0] clr_mask;
  logic [rpit_pkg::IDX_W-1:0] partner;
  logic                       idx_ok;
  logic                       trig_ok;
  logic                       is_tick;
  logic [32:0]                dur_ext;
  logic [32:0]                dur_sat;
  logic [DURATION_BITS-1:0]   dur_load;

  assign is_tick = (item.cmd == rpit_pkg::CMD_TICK);
  assign partner = item.relay_index ^ rpit_pkg::IDX_W'(1);
  assign idx_ok  = (32'(item.relay_index) < 32'(SLOTS));
  assign trig_ok = !is_tick && idx_ok && !busy[item.relay_index] && !busy[partner];

  assign dur_ext  = 33'(item.pulse_ms);
  assign dur_sat  = (dur_ext > DUR_MAX) ? DUR_MAX : dur_ext;
  assign dur_load = dur_sat[DURATION_BITS-1:0];

  assign clr_mask = rpit_pkg::IMG_W'(1) << item.relay_index;

  for (genvar i = 0; i < rpit_pkg::IMG_W; i++) begin : g_slot
    if (i < SLOTS) begin : g_live
      logic                     running;
      logic [DURATION_BITS-1:0] left;
      logic [DURATION_BITS-1:0] left_dec;
      logic                     load;

      assign left_dec = (left != '0) ? left - DURATION_BITS'(1) : left;
      assign busy[i]  = running && (left != '0);
      assign ends[i]  = running && (left_dec == '0);
      assign load     = trig_ok && (item.relay_index == rpit_pkg::IDX_W'(i));

      always_ff @(posedge clk) begin
        if (rst) begin
          running <= 1'b0;
        end else if (go) begin
          if (load) begin
            running <= 1'b1;
          end else if (is_tick && ends[i]) begin
            running <= 1'b0;
          end
        end
      end

      always_ff @(posedge clk) begin
        if (go) begin
          if (load) begin
            left <= dur_load;
          end else if (is_tick && running) begin
            left <= left_dec;
          end
        end
      end
    end else begin : g_none
      assign busy[i] = 1'b0;
      assign ends[i] = 1'b0;
    end
  end

  always_comb begin
    img_next = img;
    if (is_tick) begin
      img_next = img | ends;
    end else if (trig_ok) begin
      img_next = img & ~clr_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      img       <= '1;
      last_sent <= '1;
    end else if (go) begin
      img <= img_next;
      if (is_tick) begin
        last_sent <= img_next;
      end
    end
  end

  assign res.relay_bits  = img_next;
  assign res.accepted    = trig_ok;
  assign res.send_update = is_tick ? ((ends != '0) || (img_next != last_sent)) : trig_ok;

endmodule

>>> rtl/core/relay_pulse_interlock_timer_unit.sv
// Words pass the input reg, then the result reg; one word per cycle unless output stalls.
// While a result waits, the input reg takes one more word.
// Every tick updates all running countdowns in parallel; a trigger is one compare and one write.
// Reset (rst, synchronous): all relays off (image all ones), no pulse running, both
// stages empty. Countdown values are not reset; they are loaded by each trigger.
module relay_pulse_interlock_timer_unit #(
  parameter int RELAY_COUNT   = 8,
  parameter int DURATION_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [2:0] relay_index, [26:3] pulse_ms, rest zero
  input  logic [0:0]  s_axis_tuser,  // [0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] relay_bits
  output logic [1:0]  m_axis_tuser   // [0] accepted, [1] send_update
);

  logic              in_valid;
  rpit_pkg::item_t   in_item;
  logic              adv;
  rpit_pkg::result_t core_res;
  rpit_pkg::result_t out_res;

  assign adv           = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.cmd         <= s_axis_tuser[0];
      in_item.relay_index <= s_axis_tdata[rpit_pkg::IDX_W-1:0];
      in_item.pulse_ms    <= s_axis_tdata[rpit_pkg::IDX_W +: rpit_pkg::DUR_W];
    end
  end

  rpit_core #(
    .RELAY_COUNT   (RELAY_COUNT),
    .DURATION_BITS (DURATION_BITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .go   (adv),
    .item (in_item),
    .res  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res <= core_res;
    end
  end

  assign m_axis_tdata = out_res.relay_bits;
  assign m_axis_tuser = {out_res.send_update, out_res.accepted};

endmodule

>>> rtl/core/rpit_checker.sv
// Port-level checks for relay_pulse_interlock_timer_unit, bound to the top level.
// Depends only on the top level's ports.
module rpit_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  a_acc_send: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[1])
    else $error("accepted trigger without update request");

  a_acc_bit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata != 8'hFF)
    else $error("accepted trigger left all relays off");

  a_rst: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

bind relay_pulse_interlock_timer_unit rpit_checker u_rpit_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
